[rtl/cbnv_pkg.sv]
// ----------------------------------------------------------------------------
// cbnv_pkg
// Types, register indexes, constants and the xorshift32 noise step of the clap burst noise voice.
// ----------------------------------------------------------------------------
package cbnv_pkg;

    typedef struct packed {
        logic        trigger;
        logic [15:0] velocity;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] sample;
        logic               active;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LEVEL,
        ST_ZCHK,
        ST_DECAY,
        ST_VG,
        ST_SCALE,
        ST_PROD,
        ST_DONE
    } state_t;

    localparam logic [2:0] REG_DECAY     = 3'd0;
    localparam logic [2:0] REG_GAP       = 3'd1;
    localparam logic [2:0] REG_LEVEL     = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_GAIN      = 3'd4;
    localparam logic [2:0] REG_SEED      = 3'd5;

    localparam logic [23:0] DECAY_RESET     = 24'd16775469;
    localparam logic [9:0]  GAP_RESET       = 10'd528;
    localparam logic [21:0] LEVEL_RESET     = 22'd2936013;
    localparam logic [23:0] THRESHOLD_RESET = 24'd419;
    localparam logic [15:0] GAIN_RESET      = 16'd65535;
    localparam logic [31:0] SEED_RESET      = 32'd2463534242;

    localparam logic [9:0]  TICK_MAX = 10'd1023;
    localparam logic [23:0] AMP_MAX  = 24'hFFFFFF;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

[rtl/clap_burst_noise_voice_core.sv]
// ----------------------------------------------------------------------------
// clap_burst_noise_voice_core
// Hand-clap voice: triggered noise bursts with decaying amplitude, one
// output item per sample tick, computed on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | item
//  src     | src_valid, src_stall, src_item   | in        | trigger, velocity
//  dst     | dst_valid, dst_stall, dst_item   | out       | sample, active
//  cfg     | cfg_we, cfg_index, cfg_data      | in        | register write
//
//  from acceptance to its result in the output register, a sounding tick runs
//  up to five products through the one 25x33 multiplier, one product per
//  cycle; an idle tick ends after one check.
//  src_stall is high while an item is in work; the next item is accepted
//  while a result still waits in the output register.
//  reset loads the register defaults, the noise seed and a silent voice.
// ----------------------------------------------------------------------------
module clap_burst_noise_voice_core
    import cbnv_pkg::*;
#(
    parameter int BURST_COUNT = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  in_item_t    src_item,
    output logic        dst_valid,
    input  logic        dst_stall,
    output out_item_t   dst_item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int BW = $clog2(BURST_COUNT + 1);
    localparam logic [BW-1:0] BURSTS_FULL = BW'(BURST_COUNT);

    state_t state_reg, state_next;

    logic [23:0] decay_reg;
    logic [9:0]  gap_reg;
    logic [21:0] level_reg;
    logic [23:0] threshold_reg;
    logic [15:0] gain_reg;

    logic [31:0]   noise_reg, noise_next;
    logic [23:0]   amp_reg, amp_next;
    logic [BW-1:0] bursts_reg, bursts_next;
    logic [9:0]    ticks_reg, ticks_next;
    logic [15:0]   vel_reg, vel_next;

    logic signed [57:0] prod_reg;
    logic [23:0]        mul_a;
    logic signed [32:0] mul_b;
    logic signed [57:0] mul_p;

    out_item_t res_reg, res_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    logic        accept;
    logic        out_free;
    logic        fire;
    logic [9:0]  ticks_inc;

    assign accept    = src_valid && (state_reg == ST_IDLE);
    assign src_stall = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !dst_stall;
    assign dst_valid = out_valid_reg;
    assign dst_item  = out_reg;

    assign fire      = (bursts_reg != '0) && (ticks_reg > gap_reg);
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 10'd1;

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (bursts_reg == '0 && amp_reg < threshold_reg)
                    state_next = ST_DONE;
                else if (fire)
                    state_next = ST_LEVEL;
                else
                    state_next = ST_ZCHK;
            end
            ST_LEVEL: state_next = ST_ZCHK;
            ST_ZCHK:
            begin
                if (amp_reg == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_DECAY;
            end
            ST_DECAY: state_next = ST_VG;
            ST_VG:    state_next = ST_SCALE;
            ST_SCALE: state_next = ST_PROD;
            ST_PROD:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        noise_next     = noise_reg;
        amp_next       = amp_reg;
        bursts_next    = bursts_reg;
        ticks_next     = ticks_reg;
        vel_next       = vel_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && dst_stall;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && src_item.trigger)
                begin
                    bursts_next = BURSTS_FULL;
                    ticks_next  = '0;
                    vel_next    = src_item.velocity;
                end
            end
            ST_CHECK:
            begin
                mul_a = 24'(level_reg);
                mul_b = 33'(bursts_reg);
                if (bursts_reg == '0 && amp_reg < threshold_reg)
                begin
                    ticks_next = ticks_inc;
                    res_next   = '0;
                end
            end
            ST_LEVEL:
            begin
                amp_next    = (|prod_reg[57:24]) ? AMP_MAX : prod_reg[23:0];
                bursts_next = bursts_reg - BW'(1);
                ticks_next  = '0;
            end
            ST_ZCHK:
            begin
                mul_a = amp_reg;
                mul_b = 33'(decay_reg);
                if (amp_reg == '0)
                begin
                    ticks_next = ticks_inc;
                    res_next   = '0;
                end
            end
            ST_DECAY:
            begin
                amp_next   = prod_reg[47:24];
                noise_next = xorshift32(noise_reg);
                mul_a      = 24'(vel_reg);
                mul_b      = 33'(gain_reg);
            end
            ST_VG:
            begin
                mul_a = amp_reg;
                mul_b = 33'(prod_reg[31:16]);
            end
            ST_SCALE:
            begin
                // noise as signed q1.31: state minus half range
                mul_a = prod_reg[39:16];
                mul_b = {~noise_reg[31], ~noise_reg[31], noise_reg[30:0]};
            end
            ST_PROD:
            begin
                res_next.sample = prod_reg[56:33];
                res_next.active = 1'b1;
                ticks_next      = ticks_inc;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase

        if (cfg_we && cfg_index == REG_SEED)
            noise_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            noise_reg     <= SEED_RESET;
            amp_reg       <= '0;
            bursts_reg    <= '0;
            ticks_reg     <= TICK_MAX;
            vel_reg       <= '0;
            decay_reg     <= DECAY_RESET;
            gap_reg       <= GAP_RESET;
            level_reg     <= LEVEL_RESET;
            threshold_reg <= THRESHOLD_RESET;
            gain_reg      <= GAIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            noise_reg     <= noise_next;
            amp_reg       <= amp_next;
            bursts_reg    <= bursts_next;
            ticks_reg     <= ticks_next;
            vel_reg       <= vel_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DECAY:     decay_reg     <= cfg_data[23:0];
                    REG_GAP:       gap_reg       <= cfg_data[9:0];
                    REG_LEVEL:     level_reg     <= cfg_data[21:0];
                    REG_THRESHOLD: threshold_reg <= cfg_data[23:0];
                    REG_GAIN:      gain_reg      <= cfg_data[15:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

[test/tb_clap_burst_noise_voice_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clap_burst_noise_voice_core
// Self-checking bench for the clap voice: a directed run through the corner
// cases, then phases of random claps under changing register settings.
// Every accepted tick is run through a bit-true clap predictor and every
// output item is compared against the oldest predicted one. The sender
// works in bursts, the receiver stalls on its own pattern and once holds
// off long enough that the core backs up into its input.
// ----------------------------------------------------------------------------
module tb_clap_burst_noise_voice_core;
    import cbnv_pkg::*;

    localparam int CLAP_BURSTS  = 3;
    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 400000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        src_valid = 1'b0;
    logic        src_stall;
    in_item_t    src_item  = '0;
    logic        dst_valid;
    logic        dst_stall = 1'b0;
    out_item_t   dst_item;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    clap_burst_noise_voice_core #(
        .BURST_COUNT (CLAP_BURSTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor registers and voice state
    logic [23:0] m_decay;
    logic [9:0]  m_gap;
    logic [21:0] m_level;
    logic [23:0] m_thresh;
    logic [15:0] m_gain;
    logic [31:0] m_seed;
    logic [31:0] m_noise;
    logic [23:0] m_amp;
    logic [2:0]  m_bursts;
    logic [9:0]  m_ticks;
    logic [15:0] m_vel;

    in_item_t  tick_q[$];
    out_item_t sample_expect_q[$];
    bit        in_hand = 1'b0;
    bit        hold_req = 1'b0;
    int        mismatches = 0;
    int        strays = 0;
    int        results_seen = 0;
    int        cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_DECAY:     m_decay  = data[23:0];
            REG_GAP:       m_gap    = data[9:0];
            REG_LEVEL:     m_level  = data[21:0];
            REG_THRESHOLD: m_thresh = data[23:0];
            REG_GAIN:      m_gain   = data[15:0];
            REG_SEED:
            begin
                m_seed  = data;
                m_noise = data;
            end
            default: ;
        endcase
    endfunction

    // one sample tick of the clap voice
    function automatic out_item_t clap_tick(input in_item_t it);
        out_item_t   res;
        logic [63:0] level;
        logic [47:0] decayed;
        logic [31:0] x;
        logic [31:0] vg_w;
        logic [39:0] scaled_w;
        longint      scaled;
        longint      noise;
        longint      prod;
        bit          quiet;
        res = '0;
        if (it.trigger)
        begin
            m_bursts = 3'(CLAP_BURSTS);
            m_ticks  = '0;
            m_vel    = it.velocity;
        end
        quiet = (m_bursts == 0) && (m_amp < m_thresh);
        if (!quiet && m_bursts != 0 && m_ticks > m_gap)
        begin
            level    = 64'(m_level) * 64'(m_bursts);
            m_amp    = (level > 64'(AMP_MAX)) ? AMP_MAX : level[23:0];
            m_bursts = m_bursts - 3'd1;
            m_ticks  = '0;
        end
        if (!quiet && m_amp != 0)
        begin
            decayed  = 48'(m_amp) * 48'(m_decay);
            m_amp    = decayed[47:24];
            x        = m_noise;
            x        = x ^ {x[18:0], 13'b0};
            x        = x ^ {17'b0, x[31:17]};
            x        = x ^ {x[26:0], 5'b0};
            m_noise  = x;
            noise    = longint'(x) - longint'(64'd2147483648);
            vg_w     = 32'(m_vel) * 32'(m_gain);
            scaled_w = 40'(vg_w[31:16]) * 40'(m_amp);
            scaled   = longint'(scaled_w[39:16]);
            prod     = scaled * noise;
            res.sample = 24'(prod >>> 33);
            res.active = 1'b1;
        end
        if (m_ticks != TICK_MAX)
            m_ticks = m_ticks + 10'd1;
        return res;
    endfunction

    function automatic in_item_t tick_item(input logic trig, input logic [15:0] vel);
        in_item_t it;
        it.trigger  = trig;
        it.velocity = vel;
        return it;
    endfunction

    // unused upper data bits carry junk, the core must mask them
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value, input int width);
        logic [31:0] data;
        data = value;
        if (width < 32)
            data = data | ($urandom << width);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (tick_q.size() != 0 || in_hand || sample_expect_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // claps with room to ring out, a few stray retriggers mixed in
    task automatic queue_phase(input int count, input int gap);
        int          n;
        int          run;
        int          span;
        logic [15:0] vel;
        n    = 0;
        span = (gap < 200) ? 3 * (gap + 2) + 40 : 60;
        while (n < count)
        begin
            case ($urandom_range(0, 7))
                0:       vel = 16'hFFFF;
                1:       vel = 16'h0000;
                default: vel = 16'($urandom);
            endcase
            tick_q.push_back(tick_item(1'b1, vel));
            n++;
            run = $urandom_range(0, span);
            while (run > 0 && n < count)
            begin
                tick_q.push_back(tick_item($urandom_range(0, 19) == 0, 16'($urandom)));
                n++;
                run--;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        int burst_run;
        int gap_run;
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_item  <= '0;
            in_hand   = 1'b0;
            burst_run = 0;
            gap_run   = 0;
        end
        else
        begin
            if (src_valid && !src_stall)
            begin
                sample_expect_q.push_back(clap_tick(src_item));
                in_hand = 1'b0;
            end
            if (!in_hand)
            begin
                if (gap_run > 0)
                    gap_run--;
                else if (tick_q.size() > 0)
                begin
                    src_item <= tick_q.pop_front();
                    in_hand = 1'b1;
                    if (burst_run > 0)
                        burst_run--;
                    else
                    begin
                        burst_run = $urandom_range(0, 24);
                        gap_run   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
                    end
                end
            end
            src_valid <= in_hand;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : sink
        int seg_left;
        int stall_pct;
        int hold_left;
        bit hold_done;
        if (!rst_n)
        begin
            dst_stall <= 1'b0;
            seg_left  = 0;
            stall_pct = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            else
                seg_left--;
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dst_stall <= 1'b1;
            end
            else
                dst_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : watch
        out_item_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            results_seen++;
            if (sample_expect_q.size() == 0)
            begin
                strays++;
                if (mismatches + strays <= 10)
                    $display("item %0d: unexpected sample %0d active %0b",
                             results_seen, dst_item.sample, dst_item.active);
            end
            else
            begin
                want = sample_expect_q.pop_front();
                if (dst_item.sample !== want.sample || dst_item.active !== want.active)
                begin
                    mismatches++;
                    if (mismatches + strays <= 10)
                        $display("item %0d: sample exp %0d got %0d, active exp %0b got %0b",
                                 results_seen, want.sample, dst_item.sample,
                                 want.active, dst_item.active);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          phase;
        int          i;
        int          gap;
        logic [23:0] decay;
        logic [21:0] level;
        logic [23:0] thresh;
        logic [15:0] gain;
        logic [31:0] seed;

        m_decay  = DECAY_RESET;
        m_gap    = GAP_RESET;
        m_level  = LEVEL_RESET;
        m_thresh = THRESHOLD_RESET;
        m_gain   = GAIN_RESET;
        m_seed   = SEED_RESET;
        m_noise  = SEED_RESET;
        m_amp    = '0;
        m_bursts = '0;
        m_ticks  = TICK_MAX;
        m_vel    = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: idle tick, then a trigger that sits inside the gap at zero amplitude
        tick_q.push_back(tick_item(1'b0, 16'h0000));
        tick_q.push_back(tick_item(1'b1, 16'hFFFF));
        tick_q.push_back(tick_item(1'b0, 16'hFFFF));
        tick_q.push_back(tick_item(1'b0, 16'h0000));
        wait_drained();

        // short gap, full-scale burst level, retriggers; out-of-range indexes ignored
        write_reg(REG_GAP, 32'd1, 10);
        write_reg(REG_LEVEL, 32'h3FFFFF, 22);
        write_reg(REG_THRESHOLD, 32'd0, 24);
        write_reg(3'd6, 32'd0, 0);
        write_reg(3'd7, 32'd0, 0);
        tick_q.push_back(tick_item(1'b1, 16'hFFFF));
        for (i = 0; i < 4; i++)
            tick_q.push_back(tick_item(1'b0, 16'($urandom)));
        tick_q.push_back(tick_item(1'b1, 16'h0001));
        for (i = 0; i < 3; i++)
            tick_q.push_back(tick_item(1'b0, 16'h0000));
        tick_q.push_back(tick_item(1'b1, 16'h8000));
        tick_q.push_back(tick_item(1'b0, 16'h0000));
        tick_q.push_back(tick_item(1'b0, 16'h0000));
        wait_drained();

        // zero seed and a gap that can never be exceeded
        write_reg(REG_SEED, 32'd0, 32);
        write_reg(REG_GAP, 32'd1023, 10);
        tick_q.push_back(tick_item(1'b1, 16'hFFFF));
        for (i = 0; i < 3; i++)
            tick_q.push_back(tick_item(1'b0, 16'h0000));
        wait_drained();

        write_reg(REG_GAIN, 32'd0, 16);
        write_reg(REG_DECAY, 32'd0, 24);
        tick_q.push_back(tick_item(1'b0, 16'h5555));
        tick_q.push_back(tick_item(1'b0, 16'hAAAA));

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:       decay = 24'hFFFFFF;
                1:       decay = 24'h000000;
                default: decay = ($urandom_range(0, 1) == 1) ?
                                 (24'hFF0000 | 24'($urandom_range(0, 16'hFFFF))) :
                                 24'($urandom);
            endcase
            case (phase)
                2:       gap = 1023;
                3:       gap = 0;
                4:       gap = $urandom_range(40, 100);
                default: gap = $urandom_range(1, 24);
            endcase
            case (phase)
                0:       level = 22'h3FFFFF;
                5:       level = 22'h000000;
                default: level = 22'($urandom);
            endcase
            case (phase)
                1:       thresh = 24'hFFFFFF;
                3:       thresh = 24'h000000;
                default: thresh = 24'($urandom_range(0, 16'hFFFF));
            endcase
            case (phase)
                4:       gain = 16'h0000;
                6:       gain = 16'hFFFF;
                default: gain = 16'($urandom);
            endcase
            case (phase)
                5:       seed = 32'h00000000;
                7:       seed = 32'hFFFFFFFF;
                default: seed = $urandom;
            endcase
            write_reg(REG_DECAY, 32'(decay), 24);
            write_reg(REG_GAP, 32'(gap), 10);
            write_reg(REG_LEVEL, 32'(level), 22);
            write_reg(REG_THRESHOLD, 32'(thresh), 24);
            write_reg(REG_GAIN, 32'(gain), 16);
            write_reg(REG_SEED, seed, 32);
            if (phase == 3)
                hold_req <= 1'b1;
            queue_phase(PHASE_TICKS, gap);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && strays == 0 && sample_expect_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/cbnv_pkg.sv
rtl/clap_burst_noise_voice_core.sv
test/tb_clap_burst_noise_voice_core.sv
